// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the remapped line tag store.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");
// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/rlts_pkg.sv =====
// Package for the remapped line tag store: action codes, field widths,
// parameter defaults, controller state and command/status structs.
`timescale 1ns / 1ps
`default_nettype none
package rlts_pkg;

   // parameter defaults
   localparam int WAYS_DEF             = 64;
   localparam int EXTRA_INDEX_BITS_DEF = 4;
   localparam int BLOCK_BYTES_DEF      = 64;
   localparam int ADDRESS_BITS_DEF     = 48;

   // fixed field widths
   localparam int ACTION_BITS   = 2;
   localparam int DOMAIN_BITS   = 8;
   localparam int WAY_OUT_BITS  = 6;
   localparam int TAG_OUT_BITS  = 32;
   localparam int LINE_OUT_BITS = 10;
   localparam int RWAY_RANGE    = 2 ** WAY_OUT_BITS;

   // action codes; the fourth code behaves as a lookup
   localparam logic [ACTION_BITS-1:0] ACT_LOOKUP = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_FILL   = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_INVAL  = 2'd2;
   localparam logic [ACTION_BITS-1:0] ACT_PROBE  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_SELECT,
      ST_UPDATE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;
      logic load_vec;
      logic load_sel;
      logic commit;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;
   } dpath_stat_type;

endpackage
`default_nettype wire

// ===== sv/rlts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rlts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== sv/rlts_ctrl.sv =====
// Controller of the remapped line tag store: sequences compare, select and
// update for one item. Depends on rlts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rlts_ctrl
   import rlts_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   output ctrl_cmd_type        cmd,
   input  wire dpath_stat_type stat
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            cmd.load_vec = 1'b1;
            state_in     = ST_SELECT;
         end
         ST_SELECT: begin
            cmd.load_sel = 1'b1;
            state_in     = ST_UPDATE;
         end
         ST_UPDATE: begin
            // wait until the output register can take the result
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== sv/rlts_dpath.sv =====
// Datapath of the remapped line tag store: request register, entry cells
// with parallel key/tag compare, way select, payload RAM and output register.
// Depends on rlts_pkg and rlts_ram.
`timescale 1ns / 1ps
`default_nettype none
module rlts_dpath
   import rlts_pkg::*;
#(
   parameter int WAYS             = WAYS_DEF,
   parameter int EXTRA_INDEX_BITS = EXTRA_INDEX_BITS_DEF,
   parameter int BLOCK_BYTES      = BLOCK_BYTES_DEF,
   parameter int ADDRESS_BITS     = ADDRESS_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ctrl_cmd_type             cmd,
   output dpath_stat_type                stat,
   input  wire logic [ACTION_BITS-1:0]   req_action,
   input  wire logic [ADDRESS_BITS-1:0]  req_address,
   input  wire logic [DOMAIN_BITS-1:0]   req_domain_id,
   input  wire logic                     req_protect_flag,
   input  wire logic                     req_global_flag,
   input  wire logic [WAY_OUT_BITS-1:0]  req_random_way,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_hit,
   output logic                          rsp_key_match,
   output logic [WAY_OUT_BITS-1:0]       rsp_way,
   output logic                          rsp_evicted_valid,
   output logic [TAG_OUT_BITS-1:0]       rsp_evicted_tag,
   output logic [LINE_OUT_BITS-1:0]      rsp_evicted_line_number,
   output logic [DOMAIN_BITS-1:0]        rsp_evicted_domain,
   output logic                          rsp_evicted_protect
);

   // address split
   localparam int WIDX      = $clog2(WAYS);
   localparam int OFF_BITS  = $clog2(BLOCK_BYTES + 1) - 1;
   localparam int LN_BITS   = $clog2(WAYS + 1) - 1 + EXTRA_INDEX_BITS;
   localparam int TAG_SHIFT = OFF_BITS + LN_BITS;
   localparam int TAG_AVAIL = ADDRESS_BITS - TAG_SHIFT;
   localparam int TAG_BITS  = (TAG_AVAIL < TAG_OUT_BITS) ? TAG_AVAIL : TAG_OUT_BITS;
   localparam int PAY_BITS  = TAG_BITS + LN_BITS + DOMAIN_BITS + 1;

   // request register
   logic [ACTION_BITS-1:0] action_ff;
   logic [TAG_BITS-1:0]    tag_ff;
   logic [LN_BITS-1:0]     line_ff;
   logic [DOMAIN_BITS-1:0] dom_ff;
   logic                   prot_ff;
   logic [WIDX-1:0]        rway_ff;
   logic [WIDX-1:0]        rway_tab [RWAY_RANGE];

   // entry cells
   logic                   valid_ff [WAYS];
   logic [TAG_BITS-1:0]    cell_tag_ff [WAYS];
   logic [LN_BITS-1:0]     cell_line_ff [WAYS];
   logic [DOMAIN_BITS-1:0] cell_dom_ff [WAYS];
   logic                   cell_prot_ff [WAYS];

   // compare and select
   logic [WAYS-1:0] key_vec_in, tag_vec_in;
   logic [WAYS-1:0] key_vec_ff, tag_vec_ff;
   logic [WAYS-1:0] lowest;
   logic [WIDX-1:0] match_way, way_sel, way_ff;
   logic            km_sel, hit_sel, km_ff, hit_ff;

   // update
   logic                is_fill, is_inval, ev_valid;
   logic [PAY_BITS-1:0] pay_wr, pay_rd;
   logic [TAG_BITS-1:0]    ev_tag;
   logic [LN_BITS-1:0]     ev_line;
   logic [DOMAIN_BITS-1:0] ev_dom;
   logic                   ev_prot;
   logic [WIDX+WAY_OUT_BITS-1:0]    way_ext;
   logic [LN_BITS+LINE_OUT_BITS-1:0] line_ext;
   logic                   rsp_valid_ff;

   // random way wrapped into range
   for (genvar r = 0; r < RWAY_RANGE; r++) begin : g_rway
      assign rway_tab[r] = WIDX'(r % WAYS);
   end

   // capture request fields
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         action_ff <= req_action;
         tag_ff    <= req_address[TAG_SHIFT +: TAG_BITS];
         line_ff   <= req_address[OFF_BITS +: LN_BITS];
         dom_ff    <= req_global_flag ? '0 : req_domain_id;
         prot_ff   <= req_protect_flag;
         rway_ff   <= rway_tab[req_random_way];
      end
   end

   // parallel key and tag compare, one comparator per entry
   always_comb begin
      for (int g = 0; g < WAYS; g++) begin
         key_vec_in[g] = valid_ff[g] && (cell_dom_ff[g] == dom_ff) &&
                         (cell_prot_ff[g] == prot_ff) && (cell_line_ff[g] == line_ff);
         tag_vec_in[g] = (cell_tag_ff[g] == tag_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_vec) begin
         key_vec_ff <= key_vec_in;
         tag_vec_ff <= tag_vec_in;
      end
   end

   // lowest matching way, hit, chosen way
   always_comb begin
      lowest    = key_vec_ff & (~key_vec_ff + WAYS'(1));
      km_sel    = |key_vec_ff;
      hit_sel   = |(lowest & tag_vec_ff);
      match_way = '0;
      for (int g = 0; g < WAYS; g++) begin
         if (lowest[g]) begin
            match_way = match_way | WIDX'(g);
         end
      end
      way_sel = ((action_ff == ACT_FILL) && !km_sel) ? rway_ff : match_way;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_sel) begin
         way_ff <= way_sel;
         km_ff  <= km_sel;
         hit_ff <= hit_sel;
      end
   end

   // payload copy of the cells, read out for the evicted entry
   assign pay_wr = {tag_ff, line_ff, dom_ff, prot_ff};

   rlts_ram #(
      .WIDTH (PAY_BITS),
      .DEPTH (WAYS)
   ) u_pay_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && is_fill),
      .wr_addr (way_ff),
      .wr_data (pay_wr),
      .rd_en   (cmd.load_sel),
      .rd_addr (way_sel),
      .rd_data (pay_rd)
   );

   // update decisions
   always_comb begin
      is_fill  = (action_ff == ACT_FILL);
      is_inval = (action_ff == ACT_INVAL) && hit_ff;
      ev_valid = is_fill && valid_ff[way_ff];
      {ev_tag, ev_line, ev_dom, ev_prot} = ev_valid ? pay_rd : '0;
      way_ext  = {{WAY_OUT_BITS{1'b0}}, way_ff};
      line_ext = {{LINE_OUT_BITS{1'b0}}, ev_line};
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < WAYS; g++) begin
            valid_ff[g] <= 1'b0;
         end
      end else if (cmd.commit && (is_fill || is_inval)) begin
         valid_ff[way_ff] <= is_fill;
      end
   end

   // cell payload written by a fill
   always_ff @(posedge clock) begin
      if (cmd.commit && is_fill) begin
         cell_tag_ff[way_ff]  <= tag_ff;
         cell_line_ff[way_ff] <= line_ff;
         cell_dom_ff[way_ff]  <= dom_ff;
         cell_prot_ff[way_ff] <= prot_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit                 <= hit_ff;
         rsp_key_match           <= km_ff;
         rsp_way                 <= way_ext[WAY_OUT_BITS-1:0];
         rsp_evicted_valid       <= ev_valid;
         rsp_evicted_tag         <= TAG_OUT_BITS'(ev_tag);
         rsp_evicted_line_number <= line_ext[LINE_OUT_BITS-1:0];
         rsp_evicted_domain      <= ev_dom;
         rsp_evicted_protect     <= ev_prot;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

endmodule
`default_nettype wire

// ===== sv/remapped_line_tag_store.sv =====
// Top level of the remapped line tag store: controller, datapath, checks.
// Depends on rlts_pkg, rlts_ctrl, rlts_dpath, rlts_ram and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Fully associative tag store of WAYS entries, keyed by domain, protect bit
// and line number. Each item passes through accept, a parallel compare of
// all entry cells, a select of the lowest matching way (the random way for
// a fill with no key match) with the payload RAM read of the victim, and an
// update that writes a cell on a fill or a hitting invalidate and loads the
// output register, which lets the next item be accepted and compared while
// a result still waits; that item's update holds until the result is taken.
// All entries are invalid after reset; there is no clearing pass.
module remapped_line_tag_store
   import rlts_pkg::*;
#(
   parameter int WAYS             = WAYS_DEF,
   parameter int EXTRA_INDEX_BITS = EXTRA_INDEX_BITS_DEF,
   parameter int BLOCK_BYTES      = BLOCK_BYTES_DEF,
   parameter int ADDRESS_BITS     = ADDRESS_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [ACTION_BITS-1:0]   req_action,
   input  wire logic [ADDRESS_BITS-1:0]  req_address,
   input  wire logic [DOMAIN_BITS-1:0]   req_domain_id,
   input  wire logic                     req_protect_flag,
   input  wire logic                     req_global_flag,
   input  wire logic [WAY_OUT_BITS-1:0]  req_random_way,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_hit,
   output logic                          rsp_key_match,
   output logic [WAY_OUT_BITS-1:0]       rsp_way,
   output logic                          rsp_evicted_valid,
   output logic [TAG_OUT_BITS-1:0]       rsp_evicted_tag,
   output logic [LINE_OUT_BITS-1:0]      rsp_evicted_line_number,
   output logic [DOMAIN_BITS-1:0]        rsp_evicted_domain,
   output logic                          rsp_evicted_protect
);

   ctrl_cmd_type   cmd;
   dpath_stat_type stat;
   logic           rsp_ev_clear;

   rlts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   rlts_dpath #(
      .WAYS             (WAYS),
      .EXTRA_INDEX_BITS (EXTRA_INDEX_BITS),
      .BLOCK_BYTES      (BLOCK_BYTES),
      .ADDRESS_BITS     (ADDRESS_BITS)
   ) u_dpath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .stat                    (stat),
      .req_action              (req_action),
      .req_address             (req_address),
      .req_domain_id           (req_domain_id),
      .req_protect_flag        (req_protect_flag),
      .req_global_flag         (req_global_flag),
      .req_random_way          (req_random_way),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_hit                 (rsp_hit),
      .rsp_key_match           (rsp_key_match),
      .rsp_way                 (rsp_way),
      .rsp_evicted_valid       (rsp_evicted_valid),
      .rsp_evicted_tag         (rsp_evicted_tag),
      .rsp_evicted_line_number (rsp_evicted_line_number),
      .rsp_evicted_domain      (rsp_evicted_domain),
      .rsp_evicted_protect     (rsp_evicted_protect)
   );

   // all evicted data fields are zero
   assign rsp_ev_clear = ~|{rsp_evicted_tag, rsp_evicted_line_number,
                            rsp_evicted_domain, rsp_evicted_protect};

   // a hit is always also a key match
   `ASSERT_IMPLY(a_hit_has_key, clock, reset, rsp_valid && rsp_hit, rsp_key_match)
   // evicted fields read as zero when nothing was evicted
   `ASSERT_IMPLY(a_ev_zero, clock, reset, rsp_valid && !rsp_evicted_valid, rsp_ev_clear)
   // one item at a time: after an accept the input side is busy
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // an update never overwrites a result that is still held
   `ASSERT_IMPLY(a_commit_free, clock, reset, cmd.commit, stat.out_free)

endmodule
`default_nettype wire

// ===== tb/rlts_checker.sv =====
// Result checker for the remapped line tag store: watches both channels,
// keeps its own copy of the entry array and compares every returned item.
// Depends on rlts_pkg for the action codes and field widths.
`timescale 1ns / 1ps
module rlts_checker
   import rlts_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_stall,
   input  wire logic [ACTION_BITS-1:0]   req_action,
   input  wire logic [ADDRESS_BITS_DEF-1:0] req_address,
   input  wire logic [DOMAIN_BITS-1:0]   req_domain_id,
   input  wire logic                     req_protect_flag,
   input  wire logic                     req_global_flag,
   input  wire logic [WAY_OUT_BITS-1:0]  req_random_way,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   input  wire logic                     rsp_hit,
   input  wire logic                     rsp_key_match,
   input  wire logic [WAY_OUT_BITS-1:0]  rsp_way,
   input  wire logic                     rsp_evicted_valid,
   input  wire logic [TAG_OUT_BITS-1:0]  rsp_evicted_tag,
   input  wire logic [LINE_OUT_BITS-1:0] rsp_evicted_line_number,
   input  wire logic [DOMAIN_BITS-1:0]   rsp_evicted_domain,
   input  wire logic                     rsp_evicted_protect,
   output int                            fail_count,
   output int                            outstanding,
   output int                            results_checked,
   output int                            hits_seen,
   output int                            key_only_seen,
   output int                            evictions_seen
);

   localparam int WAYS        = WAYS_DEF;
   localparam int OFFSET_BITS = $clog2(BLOCK_BYTES_DEF);
   localparam int LINE_BITS   = $clog2(WAYS_DEF) + EXTRA_INDEX_BITS_DEF;
   localparam int TAG_SHIFT   = OFFSET_BITS + LINE_BITS;

   typedef struct packed {
      logic                     hit;
      logic                     key_match;
      logic [WAY_OUT_BITS-1:0]  way;
      logic                     evicted_valid;
      logic [TAG_OUT_BITS-1:0]  evicted_tag;
      logic [LINE_OUT_BITS-1:0] evicted_line_number;
      logic [DOMAIN_BITS-1:0]   evicted_domain;
      logic                     evicted_protect;
   } tag_result_type;

   // shadow copy of the entry array
   bit                        ent_valid [WAYS];
   logic [TAG_OUT_BITS-1:0]   ent_tag   [WAYS];
   logic [LINE_BITS-1:0]      ent_line  [WAYS];
   logic [DOMAIN_BITS-1:0]    ent_dom   [WAYS];
   logic                      ent_prot  [WAYS];

   tag_result_type expected_results[$];

   initial begin
      fail_count      = 0;
      outstanding     = 0;
      results_checked = 0;
      hits_seen       = 0;
      key_only_seen   = 0;
      evictions_seen  = 0;
   end

   // key search, then fill / invalidate on the shadow array
   function automatic tag_result_type access_tag_store(
      logic [ACTION_BITS-1:0] act, logic [ADDRESS_BITS_DEF-1:0] addr,
      logic [DOMAIN_BITS-1:0] dom_in, logic prot, logic glob,
      logic [WAY_OUT_BITS-1:0] rway);
      tag_result_type              r;
      logic [ADDRESS_BITS_DEF-1:0] above_off;
      logic [ADDRESS_BITS_DEF-1:0] above_line;
      logic [LINE_BITS-1:0]        line;
      logic [TAG_OUT_BITS-1:0]     tag;
      logic [DOMAIN_BITS-1:0]      dom;
      int                          w;
      bit                          found;
      r          = '0;
      above_off  = addr >> OFFSET_BITS;
      line       = above_off[LINE_BITS-1:0];
      above_line = addr >> TAG_SHIFT;
      tag        = above_line[TAG_OUT_BITS-1:0];
      dom        = glob ? '0 : dom_in;
      found      = 0;
      w          = 0;
      // lowest matching way wins
      for (int i = 0; i < WAYS; i++) begin
         if (!found && ent_valid[i] && ent_dom[i] == dom && ent_prot[i] == prot &&
             ent_line[i] == line) begin
            found = 1;
            w     = i;
         end
      end
      r.key_match = found;
      r.hit       = found && ent_tag[w] == tag;
      if (act == ACT_FILL) begin
         if (!found)
            w = int'(rway) % WAYS;
         if (ent_valid[w]) begin
            r.evicted_valid       = 1'b1;
            r.evicted_tag         = ent_tag[w];
            r.evicted_line_number = LINE_OUT_BITS'(ent_line[w]);
            r.evicted_domain      = ent_dom[w];
            r.evicted_protect     = ent_prot[w];
         end
         ent_valid[w] = 1;
         ent_tag[w]   = tag;
         ent_line[w]  = line;
         ent_dom[w]   = dom;
         ent_prot[w]  = prot;
      end else if (act == ACT_INVAL && r.hit) begin
         ent_valid[w] = 0;
      end
      r.way = WAY_OUT_BITS'(w);
      return r;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t: rsp_%s mismatch, expected %0h, got %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      tag_result_type want;
      if (reset) begin
         for (int i = 0; i < WAYS; i++) begin
            ent_valid[i] = 0;
            ent_tag[i]   = '0;
            ent_line[i]  = '0;
            ent_dom[i]   = '0;
            ent_prot[i]  = 1'b0;
         end
         expected_results.delete();
      end else begin
         // accepted request item
         if (req_valid && !req_stall)
            expected_results.push_back(access_tag_store(req_action, req_address,
               req_domain_id, req_protect_flag, req_global_flag, req_random_way));
         // accepted result item
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result item with no request waiting", $time);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               if (want.hit)
                  hits_seen++;
               else if (want.key_match)
                  key_only_seen++;
               if (want.evicted_valid)
                  evictions_seen++;
               check_field("hit", 64'(want.hit), 64'(rsp_hit));
               check_field("key_match", 64'(want.key_match), 64'(rsp_key_match));
               check_field("way", 64'(want.way), 64'(rsp_way));
               check_field("evicted_valid", 64'(want.evicted_valid),
                           64'(rsp_evicted_valid));
               check_field("evicted_tag", 64'(want.evicted_tag), 64'(rsp_evicted_tag));
               check_field("evicted_line_number", 64'(want.evicted_line_number),
                           64'(rsp_evicted_line_number));
               check_field("evicted_domain", 64'(want.evicted_domain),
                           64'(rsp_evicted_domain));
               check_field("evicted_protect", 64'(want.evicted_protect),
                           64'(rsp_evicted_protect));
            end
         end
      end
      outstanding = expected_results.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the remapped line tag store: clock, reset, request
// stimulus, result-side stalls, watchdog and verdict.
// Depends on rlts_pkg, remapped_line_tag_store and rlts_checker.
`timescale 1ns / 1ps
module tb_top;
   import rlts_pkg::*;

   localparam int HALF_PERIOD  = 4;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_ITEMS = 1530;
   localparam int QUIET_ITEMS  = 150;
   localparam int HOLD_CYCLES  = 120;
   localparam int HOLD_AT      = 500;
   localparam int DRAIN_AT     = 1000;
   localparam int TAIL_CYCLES  = 16;
   localparam int IDLE_LIMIT   = 1000;

   typedef struct {
      logic [ADDRESS_BITS_DEF-1:0] addr;
      logic [DOMAIN_BITS-1:0]      dom;
      bit                          prot;
      bit                          glob;
   } line_key_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [ACTION_BITS-1:0]        req_action = ACT_LOOKUP;
   logic [ADDRESS_BITS_DEF-1:0]   req_address = '0;
   logic [DOMAIN_BITS-1:0]        req_domain_id = '0;
   logic                          req_protect_flag = 1'b0;
   logic                          req_global_flag = 1'b0;
   logic [WAY_OUT_BITS-1:0]       req_random_way = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_hit;
   logic                          rsp_key_match;
   logic [WAY_OUT_BITS-1:0]       rsp_way;
   logic                          rsp_evicted_valid;
   logic [TAG_OUT_BITS-1:0]       rsp_evicted_tag;
   logic [LINE_OUT_BITS-1:0]      rsp_evicted_line_number;
   logic [DOMAIN_BITS-1:0]        rsp_evicted_domain;
   logic                          rsp_evicted_protect;

   int  fail_count, outstanding, results_checked, hits_seen, key_only_seen, evictions_seen;
   bit  req_took = 0;
   int  idle_cycles = 0;
   bit  quiet = 0;
   bit  hold_rsp = 0;
   int  items_sent = 0;

   line_key_type key_pool[16];

   always #(HALF_PERIOD) clock = ~clock;

   remapped_line_tag_store i_dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_action, .req_address, .req_domain_id,
      .req_protect_flag, .req_global_flag, .req_random_way,
      .rsp_valid, .rsp_stall, .rsp_hit, .rsp_key_match, .rsp_way,
      .rsp_evicted_valid, .rsp_evicted_tag, .rsp_evicted_line_number,
      .rsp_evicted_domain, .rsp_evicted_protect
   );

   rlts_checker i_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_action, .req_address, .req_domain_id,
      .req_protect_flag, .req_global_flag, .req_random_way,
      .rsp_valid, .rsp_stall, .rsp_hit, .rsp_key_match, .rsp_way,
      .rsp_evicted_valid, .rsp_evicted_tag, .rsp_evicted_line_number,
      .rsp_evicted_domain, .rsp_evicted_protect,
      .fail_count, .outstanding, .results_checked, .hits_seen,
      .key_only_seen, .evictions_seen
   );

   // handshake sampling and watchdog on cycles with no item moving
   always @(posedge clock) begin
      req_took <= req_valid && !req_stall;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side: random stall bursts, free runs, one long hold on request
   initial begin : rsp_side
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall = 1'b0;
            hold_rsp  = 0;
         end else if (quiet) begin
            rsp_stall = 1'b0;
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 9)) @(negedge clock);
            rsp_stall = 1'b0;
         end else begin
            rsp_stall = 1'b0;
            repeat ($urandom_range(0, 15)) @(negedge clock);
         end
      end
   end

   // offer one request item and wait until it is taken; valid stays high
   task automatic send_item(logic [ACTION_BITS-1:0] act, logic [ADDRESS_BITS_DEF-1:0] addr,
                            logic [DOMAIN_BITS-1:0] dom, bit prot, bit glob,
                            logic [WAY_OUT_BITS-1:0] rway);
      if (!quiet && !hold_rsp && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_action       = act;
      req_address      = addr;
      req_domain_id    = dom;
      req_protect_flag = prot;
      req_global_flag  = glob;
      req_random_way   = rway;
      do @(negedge clock); while (!req_took);
      items_sent++;
   endtask

   task automatic send_key(logic [ACTION_BITS-1:0] act, line_key_type k);
      send_item(act, k.addr, k.dom, k.prot, k.glob, WAY_OUT_BITS'($urandom_range(0, 63)));
   endtask

   // drop valid and wait for every outstanding result
   task automatic drain_results();
      req_valid = 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   // keys cluster on a few lines and tags so that hits and key-only matches occur
   function automatic line_key_type make_key();
      line_key_type k;
      logic [TAG_OUT_BITS-1:0]  tag;
      logic [LINE_OUT_BITS-1:0] line;
      tag  = ($urandom_range(0, 1) == 0) ? TAG_OUT_BITS'($urandom_range(0, 3)) : $urandom;
      line = ($urandom_range(0, 1) == 0) ? LINE_OUT_BITS'($urandom_range(0, 3))
                                         : LINE_OUT_BITS'($urandom);
      k.addr = {tag, line, 6'($urandom)};
      case ($urandom_range(0, 3))
         0:       k.dom = '0;
         1:       k.dom = '1;
         default: k.dom = DOMAIN_BITS'($urandom);
      endcase
      k.prot = 1'($urandom_range(0, 1));
      k.glob = ($urandom_range(0, 3) == 0);
      return k;
   endfunction

   initial begin : stimulus
      line_key_type k, k2;
      int           slot;
      bit           hold_done, drain_done;
      hold_done  = 0;
      drain_done = 0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      // directed: empty store, extremes, key-only matches, reuse, global, probe
      send_item(ACT_LOOKUP, 48'h0, 8'h00, 0, 0, 6'd0);
      send_item(ACT_FILL,   48'hFFFF_FFFF_FFFF, 8'hFF, 1, 0, 6'd63);
      send_item(ACT_LOOKUP, 48'hFFFF_FFFF_FFFF, 8'hFF, 1, 0, 6'd0);
      send_item(ACT_LOOKUP, 48'h0000_0000_FFFF, 8'hFF, 1, 0, 6'd0);
      send_item(ACT_FILL,   48'h0000_0000_FFC0, 8'hFF, 1, 0, 6'd5);
      send_item(ACT_INVAL,  48'hFFFF_FFFF_FFFF, 8'hFF, 1, 0, 6'd0);
      send_item(ACT_INVAL,  48'h0000_0000_FFC0, 8'hFF, 1, 0, 6'd0);
      send_item(ACT_LOOKUP, 48'h0000_0000_FFC0, 8'hFF, 1, 0, 6'd0);
      send_item(ACT_FILL,   48'h1234_5678_9AC0, 8'h4D, 0, 1, 6'd0);
      send_item(ACT_LOOKUP, 48'h1234_5678_9AC0, 8'h00, 0, 0, 6'd0);
      send_item(ACT_LOOKUP, 48'h1234_5678_9AC0, 8'hAA, 0, 0, 6'd0);
      send_item(ACT_PROBE,  48'h1234_5678_9AC0, 8'h13, 0, 1, 6'd0);
      send_item(ACT_LOOKUP, 48'h1234_5678_9AC0, 8'h00, 1, 1, 6'd0);
      send_item(ACT_FILL,   48'h0BAD_F00D_0040, 8'h01, 1, 0, 6'd0);
      send_item(ACT_FILL,   48'h0, 8'h00, 0, 0, 6'd1);
      send_item(ACT_LOOKUP, 48'h0, 8'h00, 0, 0, 6'd0);
      send_item(ACT_FILL,   48'h0BAD_F00D_0040, 8'h01, 1, 0, 6'd62);
      send_item(ACT_INVAL,  48'h5555_5555_5555, 8'h55, 1, 0, 6'd42);
      send_item(ACT_FILL,   48'hAAAA_AAAA_AAAA, 8'hAA, 0, 0, 6'd42);
      send_item(ACT_PROBE,  48'hAAAA_AAAA_AAAA, 8'hAA, 0, 0, 6'd21);
      drain_results();

      // random: mostly lookup/fill/invalidate sequences on a key pool, some noise
      foreach (key_pool[i]) key_pool[i] = make_key();
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent >= RANDOM_ITEMS - QUIET_ITEMS)
            quiet = 1;
         if (!hold_done && items_sent >= HOLD_AT) begin
            hold_rsp  = 1;
            hold_done = 1;
         end
         if (!drain_done && items_sent >= DRAIN_AT) begin
            drain_results();
            drain_done = 1;
         end
         slot = $urandom_range(0, 15);
         if ($urandom_range(0, 7) == 0)
            key_pool[slot] = make_key();
         k  = key_pool[slot];
         k2 = k;
         k2.addr[ADDRESS_BITS_DEF-1 -: TAG_OUT_BITS] = $urandom;
         case ($urandom_range(0, 9))
            0, 1: begin
               send_key(ACT_LOOKUP, k);
               send_key(ACT_FILL, k);
               send_key(ACT_LOOKUP, k);
            end
            2, 3: begin
               send_key(ACT_FILL, k);
               send_key(ACT_INVAL, k);
               send_key(ACT_LOOKUP, k);
            end
            4, 5: begin
               send_key(ACT_LOOKUP, k);
               send_key(ACT_FILL, k2);
               send_key(ACT_LOOKUP, k);
               send_key(ACT_INVAL, k);
            end
            6: begin
               send_key(ACT_PROBE, k);
               send_key(ACT_INVAL, k2);
            end
            7: begin
               // broken sequence: protect bit or domain differs from the filled key
               send_key(ACT_FILL, k);
               k.prot = !k.prot;
               if ($urandom_range(0, 1) == 0) begin
                  k.prot = !k.prot;
                  k.dom  = k.dom ^ 8'h01;
                  k.glob = 0;
               end
               send_key(ACTION_BITS'($urandom_range(0, 3)), k);
            end
            default: begin
               send_item(ACTION_BITS'($urandom_range(0, 3)),
                         ADDRESS_BITS_DEF'({$urandom, $urandom}),
                         DOMAIN_BITS'($urandom), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), WAY_OUT_BITS'($urandom_range(0, 63)));
            end
         endcase
      end
      drain_results();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Checked %0d results: %0d hits, %0d key-only matches, %0d evictions,",
               results_checked, hits_seen, key_only_seen, evictions_seen);
      $display("across directed cases, key-pool sequences, random noise and stall phases.");
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/rlts_pkg.sv
sv/rlts_ram.sv
sv/rlts_ctrl.sv
sv/rlts_dpath.sv
sv/remapped_line_tag_store.sv
tb/rlts_checker.sv
tb/tb_top.sv
